>>> hw/rtl/spem_pkg.sv
`timescale 1ns / 1ps
package spem_pkg;

	localparam int MAX_PAIRS   = 16384;
	localparam int SAMPLE_BITS = 24;
	localparam int CNT_W       = $clog2(MAX_PAIRS + 1);
	localparam int W           = 80;
	localparam int DIV_BITS    = 64;
	localparam int SQRT_STEPS  = W / 2;
	localparam int FRAC_BITS   = 23;
	localparam int STEP_W      = 7;

	localparam logic [W-1:0] FRAC_ONE = {{(W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

	localparam logic [15:0] RMS_WEIGHT_RST  = 16'd256;
	localparam logic [15:0] CORR_WEIGHT_RST = 16'd256;

	localparam logic [7:0] REG_RMS_WEIGHT  = 8'd0;
	localparam logic [7:0] REG_CORR_WEIGHT = 8'd1;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_SQRT,
		OP_FRAC
	} alu_op_t;

	typedef struct packed {
		logic [CNT_W-1:0]    n;
		logic signed [37:0]  sx;
		logic signed [37:0]  sy;
		logic [61:0]         sxx;
		logic [61:0]         syy;
		logic signed [61:0]  sxy;
		logic [63:0]         serr;
		logic [24:0]         peak;
	} acc_sums_t;

endpackage

>>> hw/rtl/spem_accum.sv
`timescale 1ns / 1ps
module spem_accum (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic signed [23:0] ref_sample,
	input  logic signed [23:0] tgt_sample,
	input  logic              last_pair,
	input  logic              fin_done,
	output logic              busy,
	output logic              go,
	output spem_pkg::acc_sums_t sums
);
	import spem_pkg::*;

	typedef enum logic [2:0] {A_IDLE, A_RR, A_TT, A_RT, A_EE, A_ADD, A_WAIT} acc_state_t;

	acc_state_t         state_q;
	logic signed [24:0] r_in, t_in, e_in;
	logic [24:0]        ae_in;
	logic signed [24:0] r_q, t_q, e_q, ma, mb;
	logic               last_q, go_q;
	logic signed [49:0] prod_q;
	acc_sums_t          s_q;

	assign r_in  = {{(25-SAMPLE_BITS){ref_sample[SAMPLE_BITS-1]}}, ref_sample[SAMPLE_BITS-1:0]};
	assign t_in  = {{(25-SAMPLE_BITS){tgt_sample[SAMPLE_BITS-1]}}, tgt_sample[SAMPLE_BITS-1:0]};
	assign e_in  = r_in - t_in;
	assign ae_in = e_in[24] ? 25'(-e_in) : 25'(e_in);

	always_comb begin
		case (state_q)
			A_TT: begin
				ma = t_q;
				mb = t_q;
			end
			A_RT: begin
				ma = r_q;
				mb = t_q;
			end
			A_EE: begin
				ma = e_q;
				mb = e_q;
			end
			default: begin
				ma = r_q;
				mb = r_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			go_q    <= 1'b0;
			last_q  <= 1'b0;
			r_q     <= '0;
			t_q     <= '0;
			e_q     <= '0;
			prod_q  <= '0;
			s_q     <= '0;
		end else begin
			go_q <= 1'b0;
			case (state_q)
				A_IDLE: begin
					if (accept) begin
						r_q    <= r_in;
						t_q    <= t_in;
						e_q    <= e_in;
						last_q <= last_pair;
						if (s_q.n < CNT_W'(MAX_PAIRS)) begin
							s_q.n  <= s_q.n + CNT_W'(1);
							s_q.sx <= s_q.sx + {{13{r_in[24]}}, r_in};
							s_q.sy <= s_q.sy + {{13{t_in[24]}}, t_in};
							if (ae_in > s_q.peak)
								s_q.peak <= ae_in;
							state_q <= A_RR;
						end else if (last_pair) begin
							go_q    <= 1'b1;
							state_q <= A_WAIT;
						end
					end
				end
				A_RR: begin
					prod_q  <= ma * mb;
					state_q <= A_TT;
				end
				A_TT: begin
					s_q.sxx <= s_q.sxx + {12'b0, prod_q};
					prod_q  <= ma * mb;
					state_q <= A_RT;
				end
				A_RT: begin
					s_q.syy <= s_q.syy + {12'b0, prod_q};
					prod_q  <= ma * mb;
					state_q <= A_EE;
				end
				A_EE: begin
					s_q.sxy <= s_q.sxy + {{12{prod_q[49]}}, prod_q};
					prod_q  <= ma * mb;
					state_q <= A_ADD;
				end
				A_ADD: begin
					s_q.serr <= s_q.serr + {14'b0, prod_q};
					if (last_q) begin
						go_q    <= 1'b1;
						state_q <= A_WAIT;
					end else begin
						state_q <= A_IDLE;
					end
				end
				A_WAIT: begin
					if (fin_done) begin
						s_q     <= '0;
						state_q <= A_IDLE;
					end
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	assign busy = (state_q != A_IDLE);
	assign go   = go_q;
	assign sums = s_q;

endmodule

>>> hw/rtl/spem_alu.sv
`timescale 1ns / 1ps
module spem_alu (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  spem_pkg::alu_op_t     op,
	input  logic [spem_pkg::W-1:0] a,
	input  logic [spem_pkg::W-1:0] b,
	output logic                  done,
	output logic [spem_pkg::W-1:0] res
);
	import spem_pkg::*;

	logic              busy_q, done_q;
	alu_op_t           op_q;
	logic [W-1:0]      x_q, y_q, z_q, res_q;
	logic [STEP_W-1:0] cnt_q;
	logic [W-1:0]      remsh, rem2, trial, xsh, p, q, sv;
	logic              sub, ge;
	logic [W:0]        sum;

	assign remsh = {z_q[W-2:0], x_q[DIV_BITS-1]};
	assign rem2  = {z_q[W-3:0], x_q[W-1:W-2]};
	assign trial = {y_q[W-3:0], 2'b01};
	assign xsh   = {x_q[W-2:0], 1'b0};

	always_comb begin
		case (op_q)
			OP_ADD: begin
				p = x_q; q = y_q; sub = 1'b0;
			end
			OP_SUB: begin
				p = x_q; q = y_q; sub = 1'b1;
			end
			OP_MUL: begin
				p = z_q; q = x_q; sub = 1'b0;
			end
			OP_DIV: begin
				p = remsh; q = y_q; sub = 1'b1;
			end
			OP_SQRT: begin
				p = rem2; q = trial; sub = 1'b1;
			end
			OP_FRAC: begin
				p = (cnt_q == '0) ? x_q : xsh; q = y_q; sub = 1'b1;
			end
			default: begin
				p = x_q; q = y_q; sub = 1'b0;
			end
		endcase
	end

	assign sum = {1'b0, p} + {1'b0, (sub ? ~q : q)} + (W+1)'(sub);
	assign ge  = sum[W];
	assign sv  = sum[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_ADD;
			cnt_q  <= '0;
			x_q    <= '0;
			y_q    <= '0;
			z_q    <= '0;
			res_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (start) begin
					busy_q <= 1'b1;
					op_q   <= op;
					x_q    <= a;
					y_q    <= b;
					z_q    <= '0;
					cnt_q  <= '0;
				end
			end else begin
				case (op_q)
					OP_ADD, OP_SUB: begin
						res_q  <= sv;
						done_q <= 1'b1;
						busy_q <= 1'b0;
					end
					OP_MUL: begin
						if (y_q == '0) begin
							res_q  <= z_q;
							done_q <= 1'b1;
							busy_q <= 1'b0;
						end else begin
							if (y_q[0])
								z_q <= sv;
							x_q <= xsh;
							y_q <= y_q >> 1;
						end
					end
					OP_DIV: begin
						z_q   <= ge ? sv : remsh;
						x_q   <= {x_q[W-2:0], ge};
						cnt_q <= cnt_q + STEP_W'(1);
						if (cnt_q == STEP_W'(DIV_BITS - 1)) begin
							res_q  <= {{(W-DIV_BITS){1'b0}}, x_q[DIV_BITS-2:0], ge};
							done_q <= 1'b1;
							busy_q <= 1'b0;
						end
					end
					OP_SQRT: begin
						z_q   <= ge ? sv : rem2;
						y_q   <= {y_q[W-2:0], ge};
						x_q   <= {x_q[W-3:0], 2'b00};
						cnt_q <= cnt_q + STEP_W'(1);
						if (cnt_q == STEP_W'(SQRT_STEPS - 1)) begin
							res_q  <= {y_q[W-2:0], ge};
							done_q <= 1'b1;
							busy_q <= 1'b0;
						end
					end
					OP_FRAC: begin
						if (cnt_q == '0) begin
							if (ge) begin
								res_q  <= FRAC_ONE;
								done_q <= 1'b1;
								busy_q <= 1'b0;
							end else begin
								cnt_q <= STEP_W'(1);
							end
						end else begin
							x_q   <= ge ? sv : xsh;
							z_q   <= {z_q[W-2:0], ge};
							cnt_q <= cnt_q + STEP_W'(1);
							if (cnt_q == STEP_W'(FRAC_BITS)) begin
								res_q  <= {z_q[W-2:0], ge};
								done_q <= 1'b1;
								busy_q <= 1'b0;
							end
						end
					end
					default: begin
						res_q  <= '0;
						done_q <= 1'b1;
						busy_q <= 1'b0;
					end
				endcase
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

>>> hw/rtl/spem_seq.sv
`timescale 1ns / 1ps
module spem_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  spem_pkg::acc_sums_t sums,
	input  logic [15:0]         rms_w,
	input  logic [15:0]         corr_w,
	input  logic                out_stall,
	output logic                fin_done,
	output logic                out_valid,
	output logic [24:0]         rms_error,
	output logic signed [23:0]  correlation,
	output logic [23:0]         peak_error,
	output logic [33:0]         total_error
);
	import spem_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DIV, ST_RMS, ST_M1, ST_N1, ST_M2, ST_N2, ST_NUM, ST_MAG,
		ST_VX1, ST_VX2, ST_VX3, ST_RX, ST_VY1, ST_VY2, ST_VY3, ST_RY,
		ST_DEN, ST_FRAC, ST_TW1, ST_TW2, ST_TOT, ST_OUT
	} seq_state_t;

	seq_state_t         state_q;
	logic               wait_q, start_q, fin_q, out_valid_q, neg_q;
	alu_op_t            op;
	logic [W-1:0]       a, b, res, t1_q, t2_q, t3_q, rx_q, ry_q;
	logic               alu_done;
	logic [37:0]        mag_sx, mag_sy;
	logic [61:0]        mag_sxy;
	logic [24:0]        rms_q, rms_o;
	logic signed [23:0] corr_q, corr_o;
	logic [23:0]        peak_o;
	logic [33:0]        total_o;
	logic [25:0]        inv;

	assign mag_sx  = sums.sx[37]  ? 38'(-sums.sx)  : 38'(sums.sx);
	assign mag_sy  = sums.sy[37]  ? 38'(-sums.sy)  : 38'(sums.sy);
	assign mag_sxy = sums.sxy[61] ? 62'(-sums.sxy) : 62'(sums.sxy);
	assign inv     = 26'd8388608 - {{2{corr_q[23]}}, corr_q};

	always_comb begin
		op = OP_ADD;
		a  = '0;
		b  = '0;
		case (state_q)
			ST_DIV:  begin op = OP_DIV;  a = W'(sums.serr); b = W'(sums.n); end
			ST_RMS:  begin op = OP_SQRT; a = t1_q; end
			ST_M1:   begin op = OP_MUL;  a = W'(mag_sxy); b = W'(sums.n); end
			ST_N1:   begin op = OP_SUB;  b = t1_q; end
			ST_M2:   begin op = OP_MUL;  a = W'(mag_sx); b = W'(mag_sy); end
			ST_N2:   begin op = OP_SUB;  b = t2_q; end
			ST_NUM:  begin op = OP_SUB;  a = t1_q; b = t2_q; end
			ST_MAG:  begin op = OP_SUB;  b = t1_q; end
			ST_VX1:  begin op = OP_MUL;  a = W'(sums.sxx); b = W'(sums.n); end
			ST_VX2:  begin op = OP_MUL;  a = W'(mag_sx); b = W'(mag_sx); end
			ST_VX3:  begin op = OP_SUB;  a = t2_q; b = t3_q; end
			ST_RX:   begin op = OP_SQRT; a = t2_q; end
			ST_VY1:  begin op = OP_MUL;  a = W'(sums.syy); b = W'(sums.n); end
			ST_VY2:  begin op = OP_MUL;  a = W'(mag_sy); b = W'(mag_sy); end
			ST_VY3:  begin op = OP_SUB;  a = t2_q; b = t3_q; end
			ST_RY:   begin op = OP_SQRT; a = t2_q; end
			ST_DEN:  begin op = OP_MUL;  a = rx_q; b = ry_q; end
			ST_FRAC: begin op = OP_FRAC; a = t1_q; b = t2_q; end
			ST_TW1:  begin op = OP_MUL;  a = W'(rms_q); b = W'(rms_w); end
			ST_TW2:  begin op = OP_MUL;  a = W'(inv); b = W'(corr_w); end
			ST_TOT:  begin op = OP_ADD;  a = t2_q; b = t3_q; end
			default: begin op = OP_ADD; end
		endcase
	end

	spem_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.op     (op),
		.a      (a),
		.b      (b),
		.done   (alu_done),
		.res    (res)
	);

	// result capture
	always_ff @(posedge clk) begin
		if (alu_done) begin
			case (state_q)
				ST_DIV:  t1_q <= res;
				ST_RMS:  rms_q <= res[24:0];
				ST_M1:   t1_q <= res;
				ST_N1:   if (sums.sxy[61]) t1_q <= res;
				ST_M2:   t2_q <= res;
				ST_N2:   if (sums.sx[37] ^ sums.sy[37]) t2_q <= res;
				ST_NUM:  t1_q <= res;
				ST_MAG: begin
					neg_q <= t1_q[W-1];
					if (t1_q[W-1])
						t1_q <= res;
				end
				ST_VX1, ST_VY1, ST_VX3, ST_VY3, ST_DEN, ST_TW1, ST_TOT: t2_q <= res;
				ST_VX2, ST_VY2, ST_TW2: t3_q <= res;
				ST_RX:   rx_q <= res;
				ST_RY:   ry_q <= res;
				ST_FRAC: begin
					if (t2_q == '0)
						corr_q <= '0;
					else if (neg_q)
						corr_q <= 24'(~res[23:0] + 24'd1);
					else
						corr_q <= res[23] ? 24'h7FFFFF : res[23:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wait_q      <= 1'b0;
			start_q     <= 1'b0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
			rms_o       <= '0;
			corr_o      <= '0;
			peak_o      <= '0;
			total_o     <= '0;
		end else begin
			start_q <= 1'b0;
			fin_q   <= 1'b0;
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (go)
						state_q <= ST_DIV;
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						rms_o       <= rms_q;
						corr_o      <= corr_q;
						peak_o      <= (sums.peak > 25'hFFFFFF) ? 24'hFFFFFF : sums.peak[23:0];
						total_o     <= (|t2_q[W-1:42]) ? '1 : t2_q[41:8];
						fin_q       <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					if (!wait_q) begin
						start_q <= 1'b1;
						wait_q  <= 1'b1;
					end else if (alu_done) begin
						wait_q  <= 1'b0;
						state_q <= seq_state_t'(state_q + 5'd1);
					end
				end
			endcase
		end
	end

	assign fin_done    = fin_q;
	assign out_valid   = out_valid_q;
	assign rms_error   = rms_o;
	assign correlation = corr_o;
	assign peak_error  = peak_o;
	assign total_error = total_o;

endmodule

>>> hw/rtl/signal_pair_error_metrics.sv
`timescale 1ns / 1ps
// each pair is taken in A_IDLE, then runs the single accumulation multiplier through
// A_RR, A_TT, A_RT, A_EE and A_ADD; a last pair adds the closing pass on the shared
// iterative unit: the 64-step divide, the 40-step roots and the shift-add multiplies,
// held by out_stall; in_stall holds off new pairs while busy; one run result per run
// arst_n clears all sums, the sequencers and the output register; weights reset to 256
module signal_pair_error_metrics (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] ref_sample,
	input  logic signed [23:0] tgt_sample,
	input  logic               last_pair,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [24:0]        rms_error,
	output logic signed [23:0] correlation,
	output logic [23:0]        peak_error,
	output logic [33:0]        total_error,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import spem_pkg::*;

	logic        busy, go, fin_done, accept;
	logic [15:0] rms_w_q, corr_w_q;
	acc_sums_t   sums;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy;
	assign accept    = in_valid && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rms_w_q  <= RMS_WEIGHT_RST;
			corr_w_q <= CORR_WEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RMS_WEIGHT:  rms_w_q  <= cfg_data;
				REG_CORR_WEIGHT: corr_w_q <= cfg_data;
				default: ;
			endcase
		end
	end

	spem_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.ref_sample (ref_sample),
		.tgt_sample (tgt_sample),
		.last_pair  (last_pair),
		.fin_done   (fin_done),
		.busy       (busy),
		.go         (go),
		.sums       (sums)
	);

	spem_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.sums        (sums),
		.rms_w       (rms_w_q),
		.corr_w      (corr_w_q),
		.out_stall   (out_stall),
		.fin_done    (fin_done),
		.out_valid   (out_valid),
		.rms_error   (rms_error),
		.correlation (correlation),
		.peak_error  (peak_error),
		.total_error (total_error)
	);

endmodule

>>> hw/rtl/spem_checker.sv
`timescale 1ns / 1ps
module spem_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               last_pair,
	input logic               out_valid,
	input logic               out_stall,
	input logic [24:0]        rms_error,
	input logic signed [23:0] correlation,
	input logic [23:0]        peak_error,
	input logic [33:0]        total_error
);

	// a last pair always starts the closing pass
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_pair |=> in_stall)
		else $error("last pair taken without going busy");

	// rms never exceeds the peak difference
	a_rms_le_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rms_error <= {1'b0, peak_error}) || (peak_error == 24'hFFFFFF))
		else $error("rms error above peak error");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(total_error) && $stable(correlation))
		else $error("stalled result changed");

endmodule

bind signal_pair_error_metrics spem_checker u_spem_checker (.*);

>>> tb/sv/signal_pair_error_metrics_tb.sv
`timescale 1ns / 1ps
module signal_pair_error_metrics_tb;
	import spem_pkg::*;

	localparam logic [7:0] REG_UNUSED = 8'd7;
	localparam longint ONE_Q23 = 64'd1 << 23;
	localparam longint TOTAL_MAX = (64'd1 << 34) - 1;

	typedef struct {
		logic [24:0]        rms;
		logic signed [23:0] corr;
		logic [23:0]        peak;
		logic [33:0]        total;
	} metrics_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [23:0] ref_sample;
	logic signed [23:0] tgt_sample;
	logic               last_pair;
	logic               out_valid;
	logic               out_stall;
	logic [24:0]        rms_error;
	logic signed [23:0] correlation;
	logic [23:0]        peak_error;
	logic [33:0]        total_error;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [7:0]         cfg_index;
	logic [15:0]        cfg_data;

	signal_pair_error_metrics u_top (.*);

	// predictor state
	longint   w_rms, w_corr;
	longint   n_pairs, s_ref, s_tgt, s_ref_sq, s_tgt_sq, s_cross, s_err_sq, peak_abs;
	metrics_t metrics_q[$];
	int       mismatches;
	int       pairs_sent;
	bit       tx_quiet, rx_quiet;
	bit       hold_req;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("** signal_pair_error_metrics: FAILED **");
		$finish;
	end

	function automatic logic [63:0] root128(logic [127:0] v);
		logic [63:0]  r, c;
		logic [127:0] cc;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			cc = {64'd0, c} * {64'd0, c};
			if (cc <= v) r = c;
		end
		return r;
	endfunction

	function automatic longint pearson_q23();
		logic signed [127:0] n, sx, sy, sxx, syy, sxy, num, mag;
		logic [127:0]        vx, vy, den;
		longint              q;
		n = 128'(n_pairs); sx = 128'(s_ref); sy = 128'(s_tgt);
		sxx = 128'(s_ref_sq); syy = 128'(s_tgt_sq); sxy = 128'(s_cross);
		num = n * sxy - sx * sy;
		vx = n * sxx - sx * sx;
		vy = n * syy - sy * sy;
		den = {64'd0, root128(vx)} * {64'd0, root128(vy)};
		if (den == 0) return 0;
		mag = (num < 0) ? -num : num;
		if (mag >= den) q = ONE_Q23;
		else q = longint'(({mag} << 23) / den);
		if (num < 0) return -q;
		return (q >= ONE_Q23) ? ONE_Q23 - 1 : q;
	endfunction

	function automatic void clear_run();
		n_pairs = 0; s_ref = 0; s_tgt = 0; s_ref_sq = 0; s_tgt_sq = 0;
		s_cross = 0; s_err_sq = 0; peak_abs = 0;
	endfunction

	function automatic void accumulate_pair(longint r, longint t, bit last);
		longint   e, rms, corr, total;
		metrics_t m;
		if (n_pairs < MAX_PAIRS) begin
			e = r - t;
			if (e < 0) e = -e;
			n_pairs++;
			s_ref += r; s_tgt += t;
			s_ref_sq += r * r; s_tgt_sq += t * t; s_cross += r * t;
			s_err_sq += e * e;
			if (e > peak_abs) peak_abs = e;
		end
		if (!last) return;
		rms = root128(128'(s_err_sq / n_pairs));
		corr = pearson_q23();
		total = (rms * w_rms + (ONE_Q23 - corr) * w_corr) >>> 8;
		if (total > TOTAL_MAX) total = TOTAL_MAX;
		m.rms = rms[24:0];
		m.corr = corr[23:0];
		m.peak = (peak_abs > 64'hFFFFFF) ? 24'hFFFFFF : peak_abs[23:0];
		m.total = total[33:0];
		metrics_q = {metrics_q, m};
		clear_run();
	endfunction

	function automatic int pick_gap(bit quiet);
		if (quiet) return 0;
		if ($urandom_range(0, 39) == 0) return $urandom_range(20, 120);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 4);
		return 0;
	endfunction

	// result checking and receiver stall
	int stall_burst, hold_cnt;
	always @(posedge clk) begin
		metrics_t m;
		if (arst_n && out_valid && !out_stall) begin
			if (metrics_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transaction at %0t", $time);
			end else begin
				m = metrics_q.pop_front();
				if (rms_error !== m.rms || correlation !== m.corr ||
				    peak_error !== m.peak || total_error !== m.total) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at %0t: exp rms %0d corr %0d peak %0d total %0d",
							$time, m.rms, m.corr, m.peak, m.total);
						$display("  got rms %0d corr %0d peak %0d total %0d",
							rms_error, correlation, peak_error, total_error);
					end
				end
			end
		end
		if (hold_req && hold_cnt == 0) hold_cnt = 4000;
		if (hold_cnt > 0) begin
			hold_cnt--;
			if (hold_cnt == 0) hold_req = 0;
			out_stall <= 1;
		end else if (stall_burst > 0) begin
			stall_burst--;
			out_stall <= 1;
		end else if (rx_quiet) begin
			out_stall <= 0;
		end else begin
			if ($urandom_range(0, 49) == 0) stall_burst = $urandom_range(20, 200);
			out_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	task automatic send_pair(logic signed [23:0] r, logic signed [23:0] t, bit last);
		int gap;
		ref_sample <= r;
		tgt_sample <= t;
		last_pair  <= last;
		in_valid   <= 1;
		do @(posedge clk); while (in_stall);
		accumulate_pair(r, t, last);
		pairs_sent++;
		gap = pick_gap(tx_quiet);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		in_valid <= 0;
		while (metrics_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [15:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == REG_RMS_WEIGHT) w_rms = data;
		else if (idx == REG_CORR_WEIGHT) w_corr = data;
		@(posedge clk);
	endtask

	function automatic logic signed [23:0] rand_sample();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
			1: return $signed(24'($urandom_range(0, 255))) - 24'sd128;
			default: return $signed(24'($urandom()));
		endcase
	endfunction

	task automatic test_extremes();
		send_pair(24'sh7FFFFF, 24'sh800000, 0);
		send_pair(24'sh800000, 24'sh7FFFFF, 0);
		send_pair(24'sh000000, 24'sh7FFFFF, 0);
		send_pair(24'sh800000, 24'sh000000, 1);
		send_pair(24'sh7FFFFF, 24'sh7FFFFF, 0);
		send_pair(24'sh800000, 24'sh800000, 1);
		wait_drain();
	endtask

	task automatic test_zero_denominator();
		send_pair(24'sd12345, -24'sd777, 1);
		send_pair(24'sd100, 24'sd5, 0);
		send_pair(24'sd100, -24'sd9, 0);
		send_pair(24'sd100, 24'sd40, 1);
		send_pair(24'sd0, 24'sd0, 0);
		send_pair(24'sd0, 24'sd0, 1);
		wait_drain();
	endtask

	task automatic test_corr_saturation();
		send_pair(24'sd1000, 24'sd1000, 0);
		send_pair(-24'sd3000, -24'sd3000, 0);
		send_pair(24'sd5, 24'sd5, 1);
		send_pair(24'sd1000, -24'sd1000, 0);
		send_pair(-24'sd3000, 24'sd3000, 0);
		send_pair(24'sh7FFFFF, -24'sh7FFFFF, 1);
		wait_drain();
	endtask

	task automatic test_weights();
		write_reg(REG_RMS_WEIGHT, 16'hFFFF);
		write_reg(REG_CORR_WEIGHT, 16'hFFFF);
		write_reg(REG_UNUSED, 16'h1234);
		send_pair(24'sh7FFFFF, 24'sh800000, 0);
		send_pair(-24'sd50, 24'sd50, 1);
		wait_drain();
		write_reg(REG_RMS_WEIGHT, 16'h0000);
		write_reg(REG_CORR_WEIGHT, 16'h0000);
		send_pair(24'sd300, -24'sd20, 0);
		send_pair(24'sd10, 24'sd900, 1);
		wait_drain();
		write_reg(REG_RMS_WEIGHT, RMS_WEIGHT_RST);
		write_reg(REG_CORR_WEIGHT, CORR_WEIGHT_RST);
	endtask

	task automatic send_run(int len);
		logic signed [23:0] r, t;
		int kind;
		kind = $urandom_range(0, 3);
		for (int i = 0; i < len; i++) begin
			r = rand_sample();
			case (kind)
				0: t = r + $signed(24'($urandom_range(0, 63))) - 24'sd32;
				1: t = r >>> $urandom_range(0, 4);
				2: t = -(r >>> 1);
				default: t = rand_sample();
			endcase
			send_pair(r, t, i == len - 1);
		end
	endtask

	task automatic test_random_runs();
		int len;
		while (pairs_sent < 1950) begin
			if ($urandom_range(0, 9) == 0) len = $urandom_range(20, 80);
			else len = $urandom_range(1, 10);
			if ($urandom_range(0, 19) == 0) begin
				tx_quiet = ~tx_quiet;
				rx_quiet = ~rx_quiet;
			end
			send_run(len);
			if ($urandom_range(0, 29) == 0) begin
				wait_drain();
				write_reg(8'($urandom_range(0, 2) == 0 ? $urandom_range(0, 255)
					: $urandom_range(0, 1)), 16'($urandom()));
			end
		end
		tx_quiet = 0;
		rx_quiet = 0;
		wait_drain();
	endtask

	task automatic test_backpressure();
		hold_req = 1;
		repeat (30) send_run($urandom_range(1, 4));
		wait_drain();
		send_run(5);
		wait_drain();
		send_run(3);
		wait_drain();
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0; ref_sample = 0; tgt_sample = 0; last_pair = 0;
		out_stall = 0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		w_rms = RMS_WEIGHT_RST;
		w_corr = CORR_WEIGHT_RST;
		clear_run();
		mismatches = 0; pairs_sent = 0;
		tx_quiet = 0; rx_quiet = 0; hold_req = 0;
		stall_burst = 0; hold_cnt = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_extremes();
		test_zero_denominator();
		test_corr_saturation();
		test_weights();
		test_backpressure();
		test_random_runs();
		repeat (600) @(posedge clk);
		if (mismatches == 0 && metrics_q.size() == 0) begin
			$display("** signal_pair_error_metrics: PASSED **");
		end else begin
			$display("** signal_pair_error_metrics: FAILED **");
		end
		$finish;
	end

endmodule
